### hw/rtl/bsa_pkg.sv
package bsa_pkg;

   // slots in the pool; slot numbers are eight bits wide
   localparam int POOL_SIZE = 256;

   // counts, pointers and the configured slot number all fit in nine bits
   localparam int CNT_W = 9;
   localparam int QUEUE_DEPTH = 2;
   localparam logic [CNT_W-1:0] SLOTS_RESET = 9'd256;

   localparam logic [7:0] BYTE_FULL = 8'hFF;
   localparam logic [7:0] MASK_NIBBLE = 8'h0F;
   localparam logic [7:0] MASK_PAIR = 8'h33;
   localparam logic [7:0] MASK_BIT = 8'h55;

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NOP = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK = 2'd0,
      STAT_FULL = 2'd1,
      STAT_RANGE = 2'd2,
      STAT_DOUBLE = 2'd3
   } status_type;

   // classified operation handed from front to back
   typedef enum logic [2:0] {
      OP_ALLOC,
      OP_FREE,
      OP_RANGE,
      OP_CLEAR,
      OP_NOP
   } op_kind_type;

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_ALLOC,
      ENG_FREE,
      ENG_SCAN
   } eng_state_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] slot_index;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] granted_slot;
      logic [8:0] free_count;
   } rsp_type;

   typedef struct packed {
      op_kind_type op;
      logic [7:0] slot_index;
      logic [CNT_W-1:0] active_count;
   } op_type;

   // position of the lowest clear bit; only meaningful for a byte that is not full
   function automatic logic [2:0] lowest_zero_bit(input logic [7:0] b);
      logic [7:0] c;
      logic [2:0] pos;
      c = ~b;
      pos = 3'd7;
      if ((c & MASK_NIBBLE) != 8'h00) begin
         pos = pos - 3'd4;
         c = c & MASK_NIBBLE;
      end
      if ((c & MASK_PAIR) != 8'h00) begin
         pos = pos - 3'd2;
         c = c & MASK_PAIR;
      end
      if ((c & MASK_BIT) != 8'h00) begin
         pos = pos - 3'd1;
      end
      return pos;
   endfunction

endpackage

### hw/rtl/bitmap_slot_allocator_core.sv
// Channel   Ports                              Moves
// --------  ---------------------------------  ------------------------------------
// request   push, full, req_data               command and slot index, queue style
// response  empty, pop, rsp_data               status, granted slot, free count
// csr       csr_wr_en, csr_wr_data             slot count, applied at next clear
//
// Order: with the engine idle, a clear, full pool, range error or unused code is
// answered from idle, a free or allocate once its byte is read; an allocate that
// fills its byte then scans one byte a cycle (up to 31) before the next request.
// Reset: synchronous; no slots held, 256 slots, queues empty. No clearing pass:
// rows carry valid bits.
// Stalls: with no pops, two responses and two requests queue up, then full rises.
module bitmap_slot_allocator_core (
   input  logic             clock,
   input  logic             reset,
   // request side
   input  logic             push,
   output logic             full,
   input  bsa_pkg::req_type  req_data,
   // response side
   output logic             empty,
   input  logic             pop,
   output bsa_pkg::rsp_type  rsp_data,
   // slot count register
   input  logic             csr_wr_en,
   input  logic [8:0]       csr_wr_data
);

   logic accept;
   bsa_pkg::op_type op_in_data;   // classified request into the queue
   bsa_pkg::op_type op_out_data;  // oldest classified request
   logic op_empty;
   logic op_pop;
   logic rsp_full;
   logic rsp_push;
   bsa_pkg::rsp_type rsp_in_data;

   assign accept = push & ~full;

   // front: decode, range check against its copy of the active count,
   // and the slot count register
   bsa_front u_front (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .req_data(req_data),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .op_data(op_in_data)
   );

   // request queue between front and engine
   bsa_fifo #(
      .ENTRY_TYPE(bsa_pkg::op_type),
      .DEPTH(bsa_pkg::QUEUE_DEPTH)
   ) u_op_queue (
      .clock(clock),
      .reset(reset),
      .push(accept),
      .push_data(op_in_data),
      .full(full),
      .pop(op_pop),
      .pop_data(op_out_data),
      .empty(op_empty)
   );

   // engine: owns the bitmap, first-free pointer and free count;
   // starts a request only when the response queue has room
   bsa_engine u_engine (
      .clock(clock),
      .reset(reset),
      .op_empty(op_empty),
      .op_data(op_out_data),
      .op_pop(op_pop),
      .rsp_full(rsp_full),
      .rsp_push(rsp_push),
      .rsp_data(rsp_in_data)
   );

   // response queue
   bsa_fifo #(
      .ENTRY_TYPE(bsa_pkg::rsp_type),
      .DEPTH(bsa_pkg::QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock(clock),
      .reset(reset),
      .push(rsp_push),
      .push_data(rsp_in_data),
      .full(rsp_full),
      .pop(pop),
      .pop_data(rsp_data),
      .empty(empty)
   );

endmodule

### hw/rtl/bsa_fifo.sv
module bsa_fifo #(
   parameter type ENTRY_TYPE = logic,
   parameter int DEPTH = 2
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  ENTRY_TYPE push_data,
   output logic      full,
   input  logic      pop,
   output ENTRY_TYPE pop_data,
   output logic      empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   ENTRY_TYPE store_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign pop_data = store_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/bsa_front.sv
module bsa_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  bsa_pkg::req_type req_data,
   input  logic            csr_wr_en,
   input  logic [8:0]      csr_wr_data,
   output bsa_pkg::op_type  op_data
);

   localparam logic [bsa_pkg::CNT_W-1:0] RESET_ACTIVE =
      bsa_pkg::CNT_W'((bsa_pkg::POOL_SIZE < 256) ? bsa_pkg::POOL_SIZE : 256);

   logic [bsa_pkg::CNT_W-1:0] slots_ff;
   logic [bsa_pkg::CNT_W-1:0] active_ff, active_in;
   logic [bsa_pkg::CNT_W-1:0] clamped;

   // slot count as a clear command will apply it
   always_comb begin
      if (slots_ff == '0) begin
         clamped = bsa_pkg::CNT_W'(1);
      end else if (int'(slots_ff) > bsa_pkg::POOL_SIZE) begin
         clamped = bsa_pkg::CNT_W'(bsa_pkg::POOL_SIZE);
      end else begin
         clamped = slots_ff;
      end
   end

   // shadow of the back's active count, kept in request order
   always_comb begin
      op_data.slot_index = req_data.slot_index;
      op_data.active_count = clamped;
      active_in = active_ff;
      case (req_data.command)
         bsa_pkg::CMD_ALLOC: begin
            op_data.op = bsa_pkg::OP_ALLOC;
         end
         bsa_pkg::CMD_FREE: begin
            if (bsa_pkg::CNT_W'(req_data.slot_index) >= active_ff) begin
               op_data.op = bsa_pkg::OP_RANGE;
            end else begin
               op_data.op = bsa_pkg::OP_FREE;
            end
         end
         bsa_pkg::CMD_CLEAR: begin
            op_data.op = bsa_pkg::OP_CLEAR;
            if (accept) begin
               active_in = clamped;
            end
         end
         default: begin
            op_data.op = bsa_pkg::OP_NOP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= bsa_pkg::SLOTS_RESET;
         active_ff <= RESET_ACTIVE;
      end else begin
         if (csr_wr_en) begin
            slots_ff <= csr_wr_data;
         end
         active_ff <= active_in;
      end
   end

endmodule

### hw/rtl/bsa_engine.sv
module bsa_engine (
   input  logic            clock,
   input  logic            reset,
   input  logic            op_empty,
   input  bsa_pkg::op_type  op_data,
   output logic            op_pop,
   input  logic            rsp_full,
   output logic            rsp_push,
   output bsa_pkg::rsp_type rsp_data
);

   localparam int MAP_BYTES = (bsa_pkg::POOL_SIZE + 7) / 8;
   localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
   localparam int CMP_W = (AW + 3 > bsa_pkg::CNT_W) ? AW + 3 : bsa_pkg::CNT_W;
   localparam logic [AW-1:0] LAST_ROW = AW'(MAP_BYTES - 1);
   localparam logic [bsa_pkg::CNT_W-1:0] RESET_ACTIVE =
      bsa_pkg::CNT_W'((bsa_pkg::POOL_SIZE < 256) ? bsa_pkg::POOL_SIZE : 256);

   bsa_pkg::eng_state_type state_ff, state_in;
   logic [bsa_pkg::CNT_W-1:0] active_ff, active_in;
   logic [bsa_pkg::CNT_W-1:0] free_ff, free_in;
   logic [bsa_pkg::CNT_W-1:0] first_ff, first_in;
   logic [7:0] slot_ff, slot_in;

   logic [7:0] map_mem [MAP_BYTES];
   logic [MAP_BYTES-1:0] valid_ff;
   logic [7:0] rd_data_ff;
   logic rd_valid_ff;
   logic [AW-1:0] rd_row_ff;

   logic [AW-1:0] rd_addr;
   logic wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0] wr_data;
   logic clear_map;
   logic [7:0] reset_row;
   logic [7:0] row_eff;
   logic [7:0] alloc_bit;
   logic [7:0] free_bit;
   logic [7:0] row_alloc;

   // rows never written since reset or the last clear read as their clear value:
   // bits at or beyond the active count set
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         reset_row[k] = (CMP_W'({rd_row_ff, 3'(k)}) >= CMP_W'(active_ff));
      end
   end

   assign row_eff = rd_valid_ff ? rd_data_ff : reset_row;
   assign alloc_bit = 8'b1 << first_ff[2:0];
   assign free_bit = 8'b1 << slot_ff[2:0];
   assign row_alloc = row_eff | alloc_bit;

   always_comb begin
      state_in = state_ff;
      active_in = active_ff;
      free_in = free_ff;
      first_in = first_ff;
      slot_in = slot_ff;
      op_pop = 1'b0;
      rsp_push = 1'b0;
      rsp_data.status = bsa_pkg::STAT_OK;
      rsp_data.granted_slot = '0;
      rsp_data.free_count = free_ff;
      rd_addr = rd_row_ff;
      wr_en = 1'b0;
      wr_addr = rd_row_ff;
      wr_data = row_alloc;
      clear_map = 1'b0;
      case (state_ff)
         bsa_pkg::ENG_IDLE: begin
            if (!op_empty && !rsp_full) begin
               op_pop = 1'b1;
               case (op_data.op)
                  bsa_pkg::OP_ALLOC: begin
                     if (free_ff == '0 || first_ff >= active_ff) begin
                        rsp_push = 1'b1;
                        rsp_data.status = bsa_pkg::STAT_FULL;
                     end else begin
                        rd_addr = AW'(first_ff >> 3);
                        state_in = bsa_pkg::ENG_ALLOC;
                     end
                  end
                  bsa_pkg::OP_FREE: begin
                     slot_in = op_data.slot_index;
                     rd_addr = AW'(op_data.slot_index >> 3);
                     state_in = bsa_pkg::ENG_FREE;
                  end
                  bsa_pkg::OP_RANGE: begin
                     rsp_push = 1'b1;
                     rsp_data.status = bsa_pkg::STAT_RANGE;
                  end
                  bsa_pkg::OP_CLEAR: begin
                     active_in = op_data.active_count;
                     free_in = op_data.active_count;
                     first_in = '0;
                     clear_map = 1'b1;
                     rsp_push = 1'b1;
                     rsp_data.free_count = op_data.active_count;
                  end
                  default: begin
                     rsp_push = 1'b1;
                  end
               endcase
            end
         end
         bsa_pkg::ENG_ALLOC: begin
            wr_en = 1'b1;
            free_in = free_ff - 1'b1;
            rsp_push = 1'b1;
            rsp_data.granted_slot = first_ff[7:0];
            rsp_data.free_count = free_ff - 1'b1;
            if (free_ff == bsa_pkg::CNT_W'(1)) begin
               first_in = active_ff;
               state_in = bsa_pkg::ENG_IDLE;
            end else if (row_alloc != bsa_pkg::BYTE_FULL) begin
               first_in = bsa_pkg::CNT_W'({rd_row_ff, bsa_pkg::lowest_zero_bit(row_alloc)});
               state_in = bsa_pkg::ENG_IDLE;
            end else if (rd_row_ff == LAST_ROW) begin
               first_in = active_ff;
               state_in = bsa_pkg::ENG_IDLE;
            end else begin
               rd_addr = rd_row_ff + 1'b1;
               state_in = bsa_pkg::ENG_SCAN;
            end
         end
         bsa_pkg::ENG_SCAN: begin
            if (row_eff != bsa_pkg::BYTE_FULL) begin
               first_in = bsa_pkg::CNT_W'({rd_row_ff, bsa_pkg::lowest_zero_bit(row_eff)});
               state_in = bsa_pkg::ENG_IDLE;
            end else if (rd_row_ff == LAST_ROW) begin
               first_in = active_ff;
               state_in = bsa_pkg::ENG_IDLE;
            end else begin
               rd_addr = rd_row_ff + 1'b1;
            end
         end
         bsa_pkg::ENG_FREE: begin
            rsp_push = 1'b1;
            state_in = bsa_pkg::ENG_IDLE;
            if ((row_eff & free_bit) == 8'h00) begin
               rsp_data.status = bsa_pkg::STAT_DOUBLE;
            end else begin
               wr_en = 1'b1;
               wr_data = row_eff & ~free_bit;
               free_in = free_ff + 1'b1;
               rsp_data.free_count = free_ff + 1'b1;
               if (bsa_pkg::CNT_W'(slot_ff) < first_ff) begin
                  first_in = bsa_pkg::CNT_W'(slot_ff);
               end
            end
         end
         default: begin
            state_in = bsa_pkg::ENG_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bsa_pkg::ENG_IDLE;
         active_ff <= RESET_ACTIVE;
         free_ff <= RESET_ACTIVE;
         first_ff <= '0;
      end else begin
         state_ff <= state_in;
         active_ff <= active_in;
         free_ff <= free_in;
         first_ff <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (reset || clear_map) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= map_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      rd_valid_ff <= valid_ff[rd_addr] & ~clear_map;
      rd_row_ff <= rd_addr;
   end

endmodule

### hw/rtl/bsa_checker.sv
module bsa_checker (
   input logic             clock,
   input logic             reset,
   input logic             full,
   input logic             empty,
   input logic             pop,
   input bsa_pkg::rsp_type  rsp_data
);

   // queues come out of reset empty
   assert property (@(posedge clock) reset |=> (empty && !full))
      else $error("queues not empty after reset");

   // a full pool is only reported with no free slot left
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.status == bsa_pkg::STAT_FULL) |-> (rsp_data.free_count == '0))
      else $error("pool full reported with free slots");

   // only a good allocation hands out a slot number
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.status != bsa_pkg::STAT_OK) |-> (rsp_data.granted_slot == '0))
      else $error("slot granted on a failed request");

   // a waiting response is held until popped
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("response changed while waiting");

endmodule

bind bitmap_slot_allocator_core bsa_checker u_checker (
   .clock(clock),
   .reset(reset),
   .full(full),
   .empty(empty),
   .pop(pop),
   .rsp_data(rsp_data)
);

### bench/bitmap_slot_allocator_core_test.sv
module bitmap_slot_allocator_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   logic             clock = 1'b0;
   logic             reset;
   logic             push;
   logic             full;
   bsa_pkg::req_type req_data;
   logic             empty;
   logic             pop;
   bsa_pkg::rsp_type rsp_data;
   logic             csr_wr_en;
   logic [8:0]       csr_wr_data;

   bitmap_slot_allocator_core dut (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_data    (req_data),
      .empty       (empty),
      .pop         (pop),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   // one directed step: either a slot count write or a request, the latter
   // with a hand-typed response where it is obvious
   typedef struct {
      logic             is_csr;
      logic [8:0]       csr_val;
      bsa_pkg::req_type req;
      logic             typed;
      bsa_pkg::rsp_type want;
   } plan_row_type;

   // random phases: slot count, requests, allocate and clear percentages
   int phase_slots[8]     = '{256, 1, 0, 13, 511, 8, 100, 17};
   int phase_len[8]       = '{420, 50, 30, 120, 180, 100, 250, 150};
   int phase_alloc_pct[8] = '{85, 50, 50, 55, 50, 55, 62, 50};
   int phase_clear_pct[8] = '{0, 2, 3, 2, 1, 2, 1, 2};

   // pool mirror
   logic [255:0] used_map;
   logic [8:0]   next_slot;
   logic [8:0]   free_left;
   logic [8:0]   active_cnt;
   logic [8:0]   cfg_slots;

   bsa_pkg::rsp_type pending_rsp[$];
   int      mismatches = 0;
   bit      calm = 1'b0;
   bit      hold_pop_req = 1'b0;

   task automatic flag_mismatch(input string msg);
      $display("%0t ns  mismatch: %s", $time, msg);
      mismatches++;
   endtask

   function automatic void clear_pool();
      logic [8:0] n;
      int s;
      n = cfg_slots;
      if (n == 9'd0) n = 9'd1;
      if (n > 9'd256) n = 9'd256;
      active_cnt = n;
      free_left = n;
      next_slot = '0;
      for (s = 0; s < 256; s++) used_map[s] = (s >= n);
   endfunction

   // first byte from from_byte upward with a clear bit, lowest clear bit in it
   function automatic void seek_free(input int from_byte);
      int i;
      int b;
      for (i = from_byte; i < 32; i++) begin
         if (used_map[i*8 +: 8] != bsa_pkg::BYTE_FULL) begin
            for (b = 7; b >= 0; b--) if (!used_map[i*8 + b]) next_slot = 9'(i*8 + b);
            return;
         end
      end
      next_slot = active_cnt;
   endfunction

   function automatic bsa_pkg::rsp_type pool_outcome(input bsa_pkg::req_type r);
      bsa_pkg::rsp_type o;
      logic [7:0] slot;
      o = '0;
      case (bsa_pkg::cmd_type'(r.command))
         bsa_pkg::CMD_ALLOC: begin
            if (free_left == 9'd0 || next_slot >= active_cnt) begin
               o.status = bsa_pkg::STAT_FULL;
            end else begin
               slot = next_slot[7:0];
               used_map[slot] = 1'b1;
               free_left--;
               o.granted_slot = slot;
               if (free_left == 9'd0) next_slot = active_cnt;
               else seek_free(int'(slot >> 3));
            end
         end
         bsa_pkg::CMD_FREE: begin
            slot = r.slot_index;
            if ({1'b0, slot} >= active_cnt) begin
               o.status = bsa_pkg::STAT_RANGE;
            end else if (!used_map[slot]) begin
               o.status = bsa_pkg::STAT_DOUBLE;
            end else begin
               used_map[slot] = 1'b0;
               if ({1'b0, slot} < next_slot) next_slot = {1'b0, slot};
               free_left++;
            end
         end
         bsa_pkg::CMD_CLEAR: clear_pool();
         default: ;
      endcase
      o.free_count = free_left;
      return o;
   endfunction

   function automatic plan_row_type op_row(input bsa_pkg::cmd_type c,
                                           input logic [7:0] idx,
                                           input logic typed,
                                           input bsa_pkg::status_type st,
                                           input logic [7:0] g, input logic [8:0] fc);
      plan_row_type row;
      row.is_csr = 1'b0;
      row.csr_val = '0;
      row.req = '{command: c, slot_index: idx};
      row.typed = typed;
      row.want = '{status: st, granted_slot: g, free_count: fc};
      return row;
   endfunction

   function automatic plan_row_type csr_row(input logic [8:0] v);
      plan_row_type row;
      row = op_row(bsa_pkg::CMD_NOP, 8'd0, 1'b0, bsa_pkg::STAT_OK, 8'd0, 9'd0);
      row.is_csr = 1'b1;
      row.csr_val = v;
      return row;
   endfunction

   // mostly frees of slots that are really held, so the pool fills and drains
   function automatic bsa_pkg::req_type pick_request(input int alloc_pct,
                                                     input int clear_pct);
      bsa_pkg::req_type r;
      int roll;
      int start;
      int k;
      int s;
      r.slot_index = 8'($urandom);
      roll = $urandom_range(99);
      if (roll < alloc_pct) begin
         r.command = bsa_pkg::CMD_ALLOC;
      end else if (roll < alloc_pct + clear_pct) begin
         r.command = bsa_pkg::CMD_CLEAR;
      end else if (roll < alloc_pct + clear_pct + 3) begin
         r.command = bsa_pkg::CMD_NOP;
      end else begin
         r.command = bsa_pkg::CMD_FREE;
         if ($urandom_range(9) < 7) begin
            start = $urandom_range(int'(active_cnt) - 1);
            for (k = 0; k < int'(active_cnt); k++) begin
               s = (start + k) % int'(active_cnt);
               if (used_map[s]) begin
                  r.slot_index = 8'(s);
                  break;
               end
            end
         end
      end
      return r;
   endfunction

   // entered at a falling edge, returns at the falling edge after acceptance
   task automatic send_req(input bsa_pkg::req_type r, input logic typed,
                           input bsa_pkg::rsp_type want);
      bsa_pkg::rsp_type got;
      while (!calm && $urandom_range(99) < 22) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (full);
      got = pool_outcome(r);
      pending_rsp.push_back(typed ? want : got);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      do @(negedge clock); while (pending_rsp.size() != 0);
   endtask

   task automatic write_slots(input logic [8:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      cfg_slots = v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic check_rsp(input bsa_pkg::rsp_type got);
      bsa_pkg::rsp_type want;
      if (pending_rsp.size() == 0) begin
         flag_mismatch($sformatf("response %h with nothing outstanding", got));
         return;
      end
      want = pending_rsp.pop_front();
      if (got.status != want.status)
         flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.granted_slot != want.granted_slot)
         flag_mismatch($sformatf("granted_slot %0d, want %0d",
                                 got.granted_slot, want.granted_slot));
      if (got.free_count != want.free_count)
         flag_mismatch($sformatf("free_count %0d, want %0d",
                                 got.free_count, want.free_count));
   endtask

   // response side: random pops, one long hold-off on request
   initial begin
      int stall;
      pop = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (hold_pop_req) begin
            hold_pop_req = 1'b0;
            pop <= 1'b0;
            for (stall = 0; stall < 80; stall++) @(negedge clock);
         end
         pop <= calm || ($urandom_range(99) >= 22);
         @(posedge clock);
         if (pop && !empty) check_rsp(rsp_data);
      end
   end

   initial begin
      plan_row_type plan[$];
      int ph;
      int n;
      int k;
      push = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      reset = 1'b1;
      cfg_slots = bsa_pkg::SLOTS_RESET;
      clear_pool();

      // full pool of 256 after reset
      plan.push_back(op_row(bsa_pkg::CMD_ALLOC, 8'hA5, 1'b1, bsa_pkg::STAT_OK,
                            8'd0, 9'd255));
      plan.push_back(op_row(bsa_pkg::CMD_FREE,  8'd0,  1'b1, bsa_pkg::STAT_OK,
                            8'd0, 9'd256));
      plan.push_back(op_row(bsa_pkg::CMD_FREE,  8'd0,  1'b1, bsa_pkg::STAT_DOUBLE,
                            8'd0, 9'd256));
      plan.push_back(op_row(bsa_pkg::CMD_ALLOC, 8'h00, 1'b1, bsa_pkg::STAT_OK,
                            8'd0, 9'd255));
      plan.push_back(op_row(bsa_pkg::CMD_FREE,  8'hFF, 1'b1, bsa_pkg::STAT_DOUBLE,
                            8'd0, 9'd255));
      plan.push_back(op_row(bsa_pkg::CMD_NOP,   8'hFF, 1'b1, bsa_pkg::STAT_OK,
                            8'd0, 9'd255));
      plan.push_back(op_row(bsa_pkg::CMD_CLEAR, 8'h5A, 1'b1, bsa_pkg::STAT_OK,
                            8'd0, 9'd256));
      // new count only lands at the next clear
      plan.push_back(csr_row(9'd1));
      plan.push_back(op_row(bsa_pkg::CMD_ALLOC, 8'd0,  1'b1, bsa_pkg::STAT_OK,
                            8'd0, 9'd255));
      plan.push_back(op_row(bsa_pkg::CMD_CLEAR, 8'd0,  1'b1, bsa_pkg::STAT_OK,
                            8'd0, 9'd1));
      plan.push_back(op_row(bsa_pkg::CMD_ALLOC, 8'd0,  1'b1, bsa_pkg::STAT_OK,
                            8'd0, 9'd0));
      plan.push_back(op_row(bsa_pkg::CMD_ALLOC, 8'd0,  1'b1, bsa_pkg::STAT_FULL,
                            8'd0, 9'd0));
      plan.push_back(op_row(bsa_pkg::CMD_FREE,  8'd1,  1'b1, bsa_pkg::STAT_RANGE,
                            8'd0, 9'd0));
      plan.push_back(op_row(bsa_pkg::CMD_FREE,  8'hFF, 1'b1, bsa_pkg::STAT_RANGE,
                            8'd0, 9'd0));
      plan.push_back(op_row(bsa_pkg::CMD_FREE,  8'd0,  1'b1, bsa_pkg::STAT_OK,
                            8'd0, 9'd1));
      // zero is taken as one, anything past the pool as the pool size
      plan.push_back(csr_row(9'd0));
      plan.push_back(op_row(bsa_pkg::CMD_CLEAR, 8'd0,  1'b1, bsa_pkg::STAT_OK,
                            8'd0, 9'd1));
      plan.push_back(csr_row(9'd511));
      plan.push_back(op_row(bsa_pkg::CMD_CLEAR, 8'd0,  1'b1, bsa_pkg::STAT_OK,
                            8'd0, 9'd256));
      plan.push_back(csr_row(9'd9));
      plan.push_back(op_row(bsa_pkg::CMD_CLEAR, 8'd0,  1'b1, bsa_pkg::STAT_OK,
                            8'd0, 9'd9));
      // fill the first byte so the pointer has to move on to the next one
      for (k = 0; k < 8; k++)
         plan.push_back(op_row(bsa_pkg::CMD_ALLOC, 8'($urandom), 1'b0,
                               bsa_pkg::STAT_OK, 8'd0, 9'd0));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            wait_drained();
            write_slots(plan[i].csr_val);
         end else begin
            send_req(plan[i].req, plan[i].typed, plan[i].want);
         end
      end

      for (ph = 0; ph < 8; ph++) begin
         wait_drained();
         write_slots(9'(phase_slots[ph]));
         send_req('{command: bsa_pkg::CMD_CLEAR, slot_index: 8'($urandom)}, 1'b0, '0);
         for (n = 0; n < phase_len[ph]; n++) begin
            calm = (ph == 6 && n < 150);
            if (ph == 0 && n == 150) hold_pop_req = 1'b1;
            if (ph == 0 && n == 300) wait_drained();
            send_req(pick_request(phase_alloc_pct[ph], phase_clear_pct[ph]), 1'b0, '0);
         end
         calm = 1'b0;
      end

      wait_drained();
      repeat (40) @(negedge clock);
      if (mismatches == 0) begin
         $display("** bitmap_slot_allocator_core: PASSED **");
      end else begin
         $display("** bitmap_slot_allocator_core: FAILED **");
      end
      $finish;
   end

   initial begin
      #800000;
      $display("** bitmap_slot_allocator_core: FAILED **");
      $finish;
   end

endmodule
